// ----- hdl/crme_pkg.sv -----
// Package with the shared types, constants and helper functions of the CIGAR merge block.
`default_nettype none
package crme_pkg;

	// Upper bound on the number of merged entries of one alignment.
	localparam int MAX_OPS = 65536;

	localparam int OP_W    = 4;
	localparam int LEN_W   = 28;
	localparam int START_W = 32;
	localparam int CNT_W   = 17;
	localparam int SPAN_W  = 44;
	localparam int END_W   = 45;

	localparam logic [CNT_W-1:0]  CNT_LIMIT = (MAX_OPS < 131071) ? CNT_W'(MAX_OPS) : '1;
	localparam logic [LEN_W-1:0]  LEN_MAX   = '1;
	localparam logic [SPAN_W-1:0] SPAN_MAX  = '1;

	// CIGAR operation codes that consume the reference.
	localparam logic [OP_W-1:0] OP_M  = 4'd0;
	localparam logic [OP_W-1:0] OP_D  = 4'd2;
	localparam logic [OP_W-1:0] OP_N  = 4'd3;
	localparam logic [OP_W-1:0] OP_EQ = 4'd7;
	localparam logic [OP_W-1:0] OP_X  = 4'd8;

	// One merged entry as it leaves the block.
	typedef struct packed {
		logic [OP_W-1:0]  merged_op;
		logic [LEN_W-1:0] merged_length;
		logic             final_entry;
		logic [CNT_W-1:0] entry_count;
		logic [END_W-1:0] read_end;
		logic             length_saturated;
	} entry_t;

	// Up to two entries pushed into the output queue in one cycle.
	typedef struct packed {
		logic [1:0] num;
		entry_t     first;
		entry_t     second;
	} push_t;

	function automatic logic consumes_ref(input logic [OP_W-1:0] op);
		return op inside {OP_M, OP_D, OP_N, OP_EQ, OP_X};
	endfunction

	// Entry counter step that stops at the limit.
	function automatic logic [CNT_W-1:0] count_inc(input logic [CNT_W-1:0] c);
		return (c < CNT_LIMIT) ? c + CNT_W'(1) : c;
	endfunction

endpackage
`default_nettype wire

// ----- hdl/crme_op_if.sv -----
// Interface of the input channel that carries one CIGAR operation per word.
`default_nettype none
interface crme_op_if
	import crme_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    op_code;
	logic [LEN_W-1:0]   op_length;
	logic               is_last;
	logic [START_W-1:0] read_start;

	modport source (output valid, output op_code, output op_length, output is_last,
		output read_start, input ready);
	modport sink (input valid, input op_code, input op_length, input is_last,
		input read_start, output ready);
endinterface
`default_nettype wire

// ----- hdl/crme_entry_if.sv -----
// Interface of the output channel that carries one merged CIGAR entry per word.
`default_nettype none
interface crme_entry_if
	import crme_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  merged_op;
	logic [LEN_W-1:0] merged_length;
	logic             final_entry;
	logic [CNT_W-1:0] entry_count;
	logic [END_W-1:0] read_end;
	logic             length_saturated;

	modport source (output valid, output merged_op, output merged_length,
		output final_entry, output entry_count, output read_end,
		output length_saturated, input ready);
	modport sink (input valid, input merged_op, input merged_length,
		input final_entry, input entry_count, input read_end,
		input length_saturated, output ready);
endinterface
`default_nettype wire

// ----- hdl/cigar_run_merge_and_end.sv -----
// Top level of the CIGAR run merge and reference end block.
//
//   channel   modport  word
//   op_ch     sink     op_code, op_length, is_last, read_start
//   entry_ch  source   merged_op, merged_length, final_entry, entry_count,
//                      read_end, length_saturated
//
// One operation word is taken per cycle while op_ch.ready is high; it is
// registered, merged by combinational logic, and its zero, one or two entries
// are written to a four-entry queue, so an entry passes the input register and
// the queue before it shows on entry_ch. A word that yields two entries is
// drained as two output words. Reset clears the alignment state and the queue.
// A stalled sink fills the queue and then holds op_ch.ready low.
`default_nettype none
module cigar_run_merge_and_end
	import crme_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	crme_op_if.sink     op_ch,
	crme_entry_if.source entry_ch
);

	push_t  push;
	logic   room;
	entry_t head;

	crme_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (op_ch.valid),
		.in_ready   (op_ch.ready),
		.op_code    (op_ch.op_code),
		.op_length  (op_ch.op_length),
		.is_last    (op_ch.is_last),
		.read_start (op_ch.read_start),
		.room       (room),
		.push       (push)
	);

	crme_out_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (entry_ch.valid),
		.out_ready (entry_ch.ready),
		.head      (head)
	);

	// Present the queue head on the output channel.
	assign entry_ch.merged_op        = head.merged_op;
	assign entry_ch.merged_length    = head.merged_length;
	assign entry_ch.final_entry      = head.final_entry;
	assign entry_ch.entry_count      = head.entry_count;
	assign entry_ch.read_end         = head.read_end;
	assign entry_ch.length_saturated = head.length_saturated;

endmodule
`default_nettype wire

// ----- hdl/crme_merge.sv -----
// Input register, run merge logic and alignment state of the CIGAR merge block.
`default_nettype none
module crme_merge
	import crme_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [OP_W-1:0]    op_code,
	input  wire logic [LEN_W-1:0]   op_length,
	input  wire logic               is_last,
	input  wire logic [START_W-1:0] read_start,
	input  wire logic               room,
	output push_t                   push
);

	logic               valid_s1;
	logic [OP_W-1:0]    op_s1;
	logic [LEN_W-1:0]   len_s1;
	logic               last_s1;
	logic [START_W-1:0] start_s1;

	logic [OP_W-1:0]   held_op_q;
	logic [LEN_W-1:0]  held_len_q;
	logic              holding_q;
	logic              held_sat_q;
	logic [SPAN_W-1:0] span_q;
	logic [CNT_W-1:0]  cnt_q;

	logic              consume;
	logic [SPAN_W:0]   span_sum;
	logic [SPAN_W-1:0] span_new;
	logic              merge;
	logic              flush;
	logic [LEN_W:0]    len_sum;
	logic [LEN_W-1:0]  new_len;
	logic              new_sat;
	logic [CNT_W-1:0]  cnt1;
	logic [CNT_W-1:0]  cnt2;
	logic [CNT_W-1:0]  cnt_new;
	logic [END_W-1:0]  end_pos;
	entry_t            e_flush;
	entry_t            e_final;

	// The staged word is consumed once the output queue has room for two entries.
	assign consume  = valid_s1 && room;
	assign in_ready = !valid_s1 || room;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1    <= op_code;
			len_s1   <= op_length;
			last_s1  <= is_last;
			start_s1 <= read_start;
		end
	end

	// Reference span, saturating, including the current operation.
	always_comb begin
		span_sum = {1'b0, span_q} + (SPAN_W + 1)'(len_s1);
		if (!consumes_ref(op_s1)) begin
			span_new = span_q;
		end else if (span_sum[SPAN_W]) begin
			span_new = SPAN_MAX;
		end else begin
			span_new = span_sum[SPAN_W-1:0];
		end
	end

	// Run merge with saturating length.
	always_comb begin
		merge   = holding_q && (op_s1 == held_op_q);
		flush   = holding_q && !merge;
		len_sum = {1'b0, held_len_q} + {1'b0, len_s1};
		if (merge) begin
			new_len = len_sum[LEN_W] ? LEN_MAX : len_sum[LEN_W-1:0];
			new_sat = held_sat_q || len_sum[LEN_W];
		end else begin
			new_len = len_s1;
			new_sat = 1'b0;
		end
	end

	// Entry counts and end position.
	always_comb begin
		cnt1    = count_inc(cnt_q);
		cnt2    = count_inc(cnt1);
		cnt_new = flush ? cnt1 : cnt_q;
		if (span_new == '0) begin
			end_pos = END_W'(start_s1);
		end else begin
			end_pos = END_W'(start_s1) + END_W'(span_new) - END_W'(1);
		end
	end

	// Assemble the entries of this word.
	always_comb begin
		e_flush.merged_op        = held_op_q;
		e_flush.merged_length    = held_len_q;
		e_flush.final_entry      = 1'b0;
		e_flush.entry_count      = cnt1;
		e_flush.read_end         = '0;
		e_flush.length_saturated = held_sat_q;

		e_final.merged_op        = op_s1;
		e_final.merged_length    = new_len;
		e_final.final_entry      = 1'b1;
		e_final.entry_count      = flush ? cnt2 : cnt1;
		e_final.read_end         = end_pos;
		e_final.length_saturated = new_sat;

		push.num    = consume ? (2'(flush) + 2'(last_s1)) : 2'd0;
		push.first  = flush ? e_flush : e_final;
		push.second = e_final;
	end

	// Alignment state; the last word returns it to reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_op_q  <= '0;
			held_len_q <= '0;
			holding_q  <= 1'b0;
			held_sat_q <= 1'b0;
			span_q     <= '0;
			cnt_q      <= '0;
		end else if (consume) begin
			if (last_s1) begin
				held_op_q  <= '0;
				held_len_q <= '0;
				holding_q  <= 1'b0;
				held_sat_q <= 1'b0;
				span_q     <= '0;
				cnt_q      <= '0;
			end else begin
				held_op_q  <= op_s1;
				held_len_q <= new_len;
				holding_q  <= 1'b1;
				held_sat_q <= new_sat;
				span_q     <= span_new;
				cnt_q      <= cnt_new;
			end
		end
	end

endmodule
`default_nettype wire

// ----- hdl/crme_out_queue.sv -----
// Four-entry output queue that takes up to two merged entries per cycle.
`default_nettype none
module crme_out_queue
	import crme_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire push_t push,
	output logic       room,
	output logic       out_valid,
	input  wire logic  out_ready,
	output entry_t     head
);

	entry_t     slot_q [4];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [2:0] cnt_q;
	logic       pop;

	assign out_valid = (cnt_q != 3'd0);
	assign pop       = out_valid && out_ready;
	assign head      = slot_q[rd_ptr_q];
	// Room for two entries, taken from registered occupancy only.
	assign room      = (cnt_q <= 3'd2);

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push.num != 2'd0) begin
			slot_q[wr_ptr_q] <= push.first;
		end
		if (push.num == 2'd2) begin
			slot_q[wr_ptr_q + 2'd1] <= push.second;
		end
	end

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push.num;
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			cnt_q <= cnt_q + 3'(push.num) - 3'(pop);
		end
	end

endmodule
`default_nettype wire
